/* hdl/assert_macros.svh */
// assertion macros used by ite_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a holds at an edge implies b holds at the same edge
`define ASSERT_SAME(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");

// a holds at an edge implies b holds at the next edge
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");

`endif

/* hdl/ite_pkg.sv */
// shared types and constants for the ipv6 text expander
// no dependencies
package ite_pkg;

  localparam int unsigned GROUPS       = 8;
  localparam int unsigned GROUP_W      = 16;
  localparam int unsigned GROUP_DIGITS = 4;
  localparam int unsigned QUEUE_DEPTH  = 4;
  localparam int unsigned QPTR_W       = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] ASCII_COLON   = 8'h3A;
  localparam logic [7:0] ASCII_ZERO    = 8'h30;
  localparam logic [7:0] ASCII_NINE    = 8'h39;
  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  localparam logic [7:0] ASCII_UPPER_F = 8'h46;
  localparam logic [7:0] ASCII_LOWER_A = 8'h61;
  localparam logic [7:0] ASCII_LOWER_F = 8'h66;

  localparam logic [5:0] COLON_MAX = 6'd63;

  typedef enum logic [1:0] {
    TOK_HEX,
    TOK_COLON,
    TOK_BAD
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t  kind;
    logic [3:0] value;
    logic       last;
  } token_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_FLUSH,
    ST_EMIT
  } back_state_t;

  typedef logic [GROUPS-1:0][GROUP_W-1:0] group_vec_t;

endpackage

/* hdl/ite_front.sv */
// front end: takes characters from the input stream and turns them into tokens
// depends on ite_pkg
module ite_front (
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [7:0]      s_axis_tdata,   // [7:0] ch
  input  logic            s_axis_tlast,
  input  logic            q_full,
  output logic            push,
  output ite_pkg::token_t tok
);

  logic [7:0] c;

  assign c             = s_axis_tdata;
  assign s_axis_tready = !q_full;
  assign push          = s_axis_tvalid && !q_full;

  always_comb begin
    tok.last  = s_axis_tlast;
    tok.kind  = ite_pkg::TOK_BAD;
    tok.value = 4'd0;
    if (c == ite_pkg::ASCII_COLON) begin
      tok.kind = ite_pkg::TOK_COLON;
    end else if (c >= ite_pkg::ASCII_ZERO && c <= ite_pkg::ASCII_NINE) begin
      tok.kind  = ite_pkg::TOK_HEX;
      tok.value = 4'(c - ite_pkg::ASCII_ZERO);
    end else if (c >= ite_pkg::ASCII_UPPER_A && c <= ite_pkg::ASCII_UPPER_F) begin
      tok.kind  = ite_pkg::TOK_HEX;
      tok.value = 4'(c - ite_pkg::ASCII_UPPER_A + 8'd10);
    end else if (c >= ite_pkg::ASCII_LOWER_A && c <= ite_pkg::ASCII_LOWER_F) begin
      tok.kind  = ite_pkg::TOK_HEX;
      tok.value = 4'(c - ite_pkg::ASCII_LOWER_A + 8'd10);
    end
  end

endmodule

/* hdl/ite_queue.sv */
// short token queue between the front end and the parser
// depends on ite_pkg
module ite_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ite_pkg::token_t push_tok,
  output logic            full,
  input  logic            pop,
  output ite_pkg::token_t pop_tok,
  output logic            empty
);

  ite_pkg::token_t                entries [ite_pkg::QUEUE_DEPTH];
  logic [ite_pkg::QPTR_W-1:0]     wr_ptr;
  logic [ite_pkg::QPTR_W-1:0]     rd_ptr;
  logic [ite_pkg::QPTR_W:0]       count;

  assign full    = (count == (ite_pkg::QPTR_W+1)'(ite_pkg::QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign pop_tok = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* hdl/ite_back.sv */
// parser: applies tokens to the group store and builds the expanded address
// depends on ite_pkg
module ite_back (
  input  logic            clk,
  input  logic            rst,
  input  ite_pkg::token_t tok,
  input  logic            q_empty,
  output logic            pop,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [127:0]    m_axis_tdata,   // [63:0] addr_high, [127:64] addr_low
  output logic            m_axis_tuser    // [0] error
);

  ite_pkg::back_state_t state, state_next;

  ite_pkg::group_vec_t  store;
  logic [3:0]           fill;
  logic [5:0]           colons;
  logic [15:0]          group_val;
  logic [2:0]           digits;
  logic                 prev_colon;
  logic                 gap;
  logic [3:0]           gap_pos;
  logic                 err;

  logic                 out_valid;
  logic [63:0]          out_high;
  logic [63:0]          out_low;
  logic                 out_err;

  logic                 load;
  logic                 out_free;

  logic [3:0]           ins;
  logic                 overflow;
  logic                 err_final;
  logic [7:0]           shamt;
  ite_pkg::group_vec_t  shifted;
  ite_pkg::group_vec_t  expanded;

  assign out_free = !out_valid || m_axis_tready;

  always_comb begin
    state_next = state;
    unique case (state)
      ite_pkg::ST_RUN:   if (!q_empty && tok.last) state_next = ite_pkg::ST_FLUSH;
      ite_pkg::ST_FLUSH: state_next = ite_pkg::ST_EMIT;
      ite_pkg::ST_EMIT:  if (out_free) state_next = ite_pkg::ST_RUN;
      default:           state_next = ite_pkg::ST_RUN;
    endcase
  end

  always_comb begin
    pop  = 1'b0;
    load = 1'b0;
    unique case (state)
      ite_pkg::ST_RUN:   pop = !q_empty;
      ite_pkg::ST_FLUSH: ;
      ite_pkg::ST_EMIT:  load = out_free;
      default:           ;
    endcase
  end

  // zero groups that fill the gap, and the right part moved up past them
  always_comb begin
    ins       = (colons < 6'(ite_pkg::GROUPS)) ? 4'(4'(ite_pkg::GROUPS) - colons[3:0]) : 4'd0;
    overflow  = gap && ((5'(fill) + 5'(ins)) > 5'(ite_pkg::GROUPS));
    err_final = err || overflow;
    shamt     = {ins, 4'b0000};
    shifted   = store << shamt;
    for (int g = 0; g < ite_pkg::GROUPS; g++) begin
      if (!gap || 4'(g) < gap_pos) begin
        expanded[g] = store[g];
      end else if (5'(g) < (5'(gap_pos) + 5'(ins))) begin
        expanded[g] = '0;
      end else begin
        expanded[g] = shifted[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ite_pkg::ST_RUN;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || load) begin
      store      <= '0;
      fill       <= '0;
      colons     <= '0;
      group_val  <= '0;
      digits     <= '0;
      prev_colon <= 1'b0;
      gap        <= 1'b0;
      gap_pos    <= '0;
      err        <= 1'b0;
    end else if (pop && !err) begin
      unique case (tok.kind)
        ite_pkg::TOK_COLON: begin
          if (colons != ite_pkg::COLON_MAX) begin
            colons <= colons + 1'b1;
          end
          prev_colon <= 1'b1;
          if (prev_colon) begin
            if (gap) begin
              err <= 1'b1;
            end else begin
              gap       <= 1'b1;
              gap_pos   <= fill;
              group_val <= '0;
              digits    <= '0;
            end
          end else if (fill == 4'(ite_pkg::GROUPS)) begin
            err <= 1'b1;
          end else begin
            store[fill[2:0]] <= group_val;
            fill             <= fill + 1'b1;
            group_val        <= '0;
            digits           <= '0;
          end
        end
        ite_pkg::TOK_HEX: begin
          if (digits == 3'(ite_pkg::GROUP_DIGITS)) begin
            err <= 1'b1;
          end else begin
            group_val  <= {group_val[11:0], tok.value};
            digits     <= digits + 1'b1;
            prev_colon <= 1'b0;
          end
        end
        default: err <= 1'b1;
      endcase
    end else if (state == ite_pkg::ST_FLUSH && !err) begin
      // the end of the text flushes the open group
      if (fill == 4'(ite_pkg::GROUPS)) begin
        err <= 1'b1;
      end else begin
        store[fill[2:0]] <= group_val;
        fill             <= fill + 1'b1;
        group_val        <= '0;
        digits           <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_err <= err_final;
      if (err_final) begin
        out_high <= '0;
        out_low  <= '0;
      end else begin
        out_high <= {expanded[0], expanded[1], expanded[2], expanded[3]};
        out_low  <= {expanded[4], expanded[5], expanded[6], expanded[7]};
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_low, out_high};
  assign m_axis_tuser  = out_err;

endmodule

/* hdl/ipv6_text_expand.sv */
// ipv6_text_expand: turns ipv6 address text into a 128-bit address
// depends on ite_pkg, ite_front, ite_queue, ite_back
//
// input stream: one ascii character per word in s_axis_tdata[7:0], s_axis_tlast
// on the final character of an address. output stream: one word per address,
// addr_high in m_axis_tdata[63:0] (first group in the top bits), addr_low in
// m_axis_tdata[127:64], error flag in m_axis_tuser; on error the address is zero.
// the front end classifies each character and writes a token into a four-deep
// queue; in its run state the parser drains one token per cycle, so characters
// run at one per cycle while it stays there. after the last character the
// parser flushes the open group, then inserts the gap groups and loads the
// output register, waiting for that register to be free. it pops no tokens
// meanwhile, but the queue keeps taking characters of the next address.
// a stalled receiver holds the result in the output register; the parser waits
// with the next one, the queue fills and s_axis_tready drops when it is full.
// reset (rst, synchronous) empties the queue, clears the parser state and drops
// m_axis_tvalid.
module ipv6_text_expand (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] ch
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,   // [63:0] addr_high, [127:64] addr_low
  output logic         m_axis_tuser    // [0] error
);

  ite_pkg::token_t push_tok;
  ite_pkg::token_t pop_tok;
  logic            push;
  logic            pop;
  logic            q_full;
  logic            q_empty;

  ite_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .q_full        (q_full),
    .push          (push),
    .tok           (push_tok)
  );

  ite_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_tok (push_tok),
    .full     (q_full),
    .pop      (pop),
    .pop_tok  (pop_tok),
    .empty    (q_empty)
  );

  ite_back u_back (
    .clk           (clk),
    .rst           (rst),
    .tok           (pop_tok),
    .q_empty       (q_empty),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

/* hdl/ite_checker.sv */
// port-level checks for ipv6_text_expand, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module ite_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic [7:0]   s_axis_tdata,
  input logic         s_axis_tlast,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [127:0] m_axis_tdata,
  input logic         m_axis_tuser
);

  // a malformed address reads as zero
  `ASSERT_SAME(a_err_zero, clk, rst, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0)

  // a stalled word stays offered
  `ASSERT_NEXT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

  // a stalled word keeps its contents
  `ASSERT_NEXT(a_out_stable, clk, rst, m_axis_tvalid && !m_axis_tready,
    $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // a refused character stays offered unchanged
  `ASSERT_NEXT(a_in_hold, clk, rst, s_axis_tvalid && !s_axis_tready,
    s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tlast))

endmodule

bind ipv6_text_expand ite_checker u_ite_checker (.*);

/* sim/tb.sv */
`timescale 1ns / 100ps
// testbench for ipv6_text_expand: streams address text one character per word
// and checks each 128-bit result against an in-bench expander; needs ite_pkg
module tb;

  localparam int NIBBLES       = ite_pkg::GROUPS * ite_pkg::GROUP_DIGITS;
  localparam int STALL_LIMIT   = 3000;
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES   = 400;

  typedef logic [7:0] text_t[$];

  typedef struct {
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic        error;
  } addr_result_t;

  typedef enum {MUT_REPLACE, MUT_EXTRA_DIGIT, MUT_EXTRA_COLON, MUT_EXTRA_GROUP,
                MUT_TRUNCATE} mutation_t;

  logic         clk = 1'b0;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata;   // [7:0] ch
  logic         s_axis_tlast;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [127:0] m_axis_tdata;   // [63:0] addr_high, [127:64] addr_low
  logic         m_axis_tuser;   // [0] error

  ipv6_text_expand u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // expander state
  logic [3:0]  nib_mem [NIBBLES];
  logic [5:0]  nib_fill;
  logic [5:0]  colon_cnt;
  logic [15:0] group_acc;
  logic [2:0]  digit_cnt;
  logic        after_colon;
  logic        gap_found;
  logic [5:0]  gap_at;
  logic        parse_bad;

  addr_result_t pending_addrs[$];

  bit src_idle;
  bit sink_idle;
  bit hold_req;
  int mismatches;
  int n_chars;
  int n_addrs;
  int n_flagged;

  function automatic void clear_parse();
    int k;
    for (k = 0; k < NIBBLES; k++) nib_mem[k] = '0;
    nib_fill    = '0;
    colon_cnt   = '0;
    group_acc   = '0;
    digit_cnt   = '0;
    after_colon = 1'b0;
    gap_found   = 1'b0;
    gap_at      = '0;
    parse_bad   = 1'b0;
  endfunction

  function automatic void close_group();
    int k;
    if (nib_fill > NIBBLES - ite_pkg::GROUP_DIGITS) begin
      parse_bad = 1'b1;
      return;
    end
    for (k = 0; k < ite_pkg::GROUP_DIGITS; k++)
      nib_mem[nib_fill + k] = group_acc[15 - 4 * k -: 4];
    nib_fill  = nib_fill + ite_pkg::GROUP_DIGITS;
    group_acc = '0;
    digit_cnt = '0;
  endfunction

  function automatic int hex_val(logic [7:0] c);
    if (c >= ite_pkg::ASCII_ZERO && c <= ite_pkg::ASCII_NINE)
      return int'(c - ite_pkg::ASCII_ZERO);
    if (c >= ite_pkg::ASCII_UPPER_A && c <= ite_pkg::ASCII_UPPER_F)
      return int'(c - ite_pkg::ASCII_UPPER_A) + 10;
    if (c >= ite_pkg::ASCII_LOWER_A && c <= ite_pkg::ASCII_LOWER_F)
      return int'(c - ite_pkg::ASCII_LOWER_A) + 10;
    return -1;
  endfunction

  function automatic void parse_char(logic [7:0] c);
    int v;
    if (c == ite_pkg::ASCII_COLON) begin
      if (colon_cnt < ite_pkg::COLON_MAX) colon_cnt++;
      if (after_colon) begin
        // second colon of a pair opens the gap; a second gap or ':::' is malformed
        if (gap_found) begin
          parse_bad = 1'b1;
          return;
        end
        gap_found = 1'b1;
        gap_at    = nib_fill;
        group_acc = '0;
        digit_cnt = '0;
      end else begin
        close_group();
      end
      after_colon = 1'b1;
    end else begin
      v = hex_val(c);
      if (v < 0 || digit_cnt >= ite_pkg::GROUP_DIGITS) begin
        parse_bad = 1'b1;
        return;
      end
      group_acc   = {group_acc[11:0], 4'(v)};
      digit_cnt   = digit_cnt + 1'b1;
      after_colon = 1'b0;
    end
  endfunction

  function automatic void expand_char(logic [7:0] c, logic is_last);
    addr_result_t r;
    int ins, k;
    logic [3:0] nib;
    if (!parse_bad) parse_char(c);
    if (!is_last) return;
    ins = 0;
    if (!parse_bad) close_group();
    if (!parse_bad && gap_found) begin
      ins = (colon_cnt < ite_pkg::GROUPS) ?
            int'(ite_pkg::GROUPS - colon_cnt) * ite_pkg::GROUP_DIGITS : 0;
      if (int'(nib_fill) + ins > NIBBLES) parse_bad = 1'b1;
    end
    r.addr_high = '0;
    r.addr_low  = '0;
    if (!parse_bad) begin
      for (k = 0; k < NIBBLES; k++) begin
        if (!gap_found || k < gap_at) nib = nib_mem[k];
        else if (k < int'(gap_at) + ins) nib = 4'h0;
        else nib = nib_mem[(k - ins) % NIBBLES];
        if (k < NIBBLES / 2) r.addr_high = {r.addr_high[59:0], nib};
        else r.addr_low = {r.addr_low[59:0], nib};
      end
    end
    r.error = parse_bad;
    pending_addrs.push_back(r);
    clear_parse();
  endfunction

  // one character word; caller sits at a falling edge
  task automatic send_char(input logic [7:0] c, input logic is_last);
    int unsigned gap;
    gap = src_idle ? $urandom_range(0, 19) : 0;
    repeat (gap) @(negedge clk);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = c;
    s_axis_tlast  = is_last;
    forever begin
      @(posedge clk);
      if (s_axis_tready) break;
    end
    expand_char(c, is_last);
    n_chars++;
    @(negedge clk);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic send_text(input text_t t);
    int i;
    for (i = 0; i < t.size(); i++) send_char(t[i], i == t.size() - 1);
  endtask

  function automatic text_t text_of(string s);
    text_t t;
    int i;
    for (i = 0; i < s.len(); i++) t.push_back(s[i]);
    return t;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] v);
    if (v < 4'd10) return ite_pkg::ASCII_ZERO + 8'(v);
    return ($urandom_range(0, 1) ? ite_pkg::ASCII_UPPER_A : ite_pkg::ASCII_LOWER_A) +
           8'(v) - 8'd10;
  endfunction

  function automatic void add_group(ref text_t t);
    int n, i;
    n = $urandom_range(1, ite_pkg::GROUP_DIGITS);
    for (i = 0; i < n; i++) t.push_back(hex_char(4'($urandom_range(0, 15))));
  endfunction

  // eight groups, optionally with a possibly empty run of them compressed into '::'
  function automatic text_t well_formed_text();
    text_t t;
    int gap_lo, gap_len, g;
    gap_lo  = -1;
    gap_len = 0;
    if ($urandom_range(0, 1)) begin
      gap_lo  = $urandom_range(0, ite_pkg::GROUPS);
      gap_len = $urandom_range(0, ite_pkg::GROUPS - gap_lo);
    end
    for (g = 0; g < ite_pkg::GROUPS; g++) begin
      if (g == gap_lo) begin
        t.push_back(ite_pkg::ASCII_COLON);
        t.push_back(ite_pkg::ASCII_COLON);
      end
      if (gap_lo >= 0 && g >= gap_lo && g < gap_lo + gap_len) continue;
      if (t.size() > 0 && t[$] != ite_pkg::ASCII_COLON) t.push_back(ite_pkg::ASCII_COLON);
      add_group(t);
    end
    if (gap_lo == ite_pkg::GROUPS) begin
      t.push_back(ite_pkg::ASCII_COLON);
      t.push_back(ite_pkg::ASCII_COLON);
    end
    return t;
  endfunction

  function automatic text_t broken_text();
    text_t t;
    int pos;
    mutation_t m;
    t   = well_formed_text();
    pos = $urandom_range(0, t.size() - 1);
    m   = mutation_t'($urandom_range(0, 4));
    case (m)
      MUT_REPLACE:     t[pos] = 8'($urandom_range(0, 255));
      MUT_EXTRA_DIGIT: t.insert(pos, hex_char(4'($urandom_range(0, 15))));
      MUT_EXTRA_COLON: t.insert(pos, ite_pkg::ASCII_COLON);
      MUT_EXTRA_GROUP: begin
        t.push_back(ite_pkg::ASCII_COLON);
        add_group(t);
      end
      default:         t = t[0:pos];
    endcase
    return t;
  endfunction

  function automatic text_t noise_text();
    text_t t;
    int n, i;
    n = $urandom_range(1, 6);
    for (i = 0; i < n; i++) t.push_back(8'($urandom_range(0, 255)));
    return t;
  endfunction

  task automatic pick_idling();
    src_idle  = ($urandom_range(0, 3) != 0);
    sink_idle = ($urandom_range(0, 3) != 0);
  endtask

  // lone colon, gap only, trailing colon, long group, bad bytes, triple colon, second gap
  task automatic test_directed();
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    send_text(text_of(":"));
    send_text(text_of("::"));
    send_text(text_of("aF09:"));
    send_text(text_of("12345"));
    send_char(8'hFF, 1'b0);
    send_char(8'h00, 1'b1);
    send_text(text_of(":::"));
    send_text(text_of("A::B::"));
  endtask

  task automatic test_well_formed();
    while (n_chars < 700) begin
      pick_idling();
      send_text(well_formed_text());
    end
  endtask

  task automatic test_malformed();
    int pick;
    while (n_chars < 1000) begin
      pick_idling();
      pick = $urandom_range(0, 9);
      if (pick < 6) send_text(broken_text());
      else if (pick < 8) send_text(noise_text());
      else send_text(well_formed_text());
    end
  endtask

  // receiver stops while characters keep coming, so the input backs up
  task automatic test_backpressure();
    int i;
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    hold_req  = 1'b1;
    for (i = 0; i < 6; i++) send_text(well_formed_text());
  endtask

  initial begin : sink
    int unsigned wait_left, hold_left;
    m_axis_tready = 1'b0;
    wait_left = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        m_axis_tready = 1'b0;
        hold_left--;
      end else if (wait_left > 0) begin
        m_axis_tready = 1'b0;
        wait_left--;
      end else begin
        m_axis_tready = 1'b1;
      end
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) wait_left = sink_idle ? $urandom_range(0, 19) : 0;
    end
  end

  always @(posedge clk) begin
    addr_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_addrs.size() == 0) begin
        $error("unexpected result word: tdata %h tuser %b", m_axis_tdata, m_axis_tuser);
        mismatches++;
      end else begin
        want = pending_addrs.pop_front();
        n_addrs++;
        if (want.error) n_flagged++;
        if (m_axis_tdata[63:0] !== want.addr_high) begin
          $error("addr_high: expected %h, got %h", want.addr_high, m_axis_tdata[63:0]);
          mismatches++;
        end
        if (m_axis_tdata[127:64] !== want.addr_low) begin
          $error("addr_low: expected %h, got %h", want.addr_low, m_axis_tdata[127:64]);
          mismatches++;
        end
        if (m_axis_tuser !== want.error) begin
          $error("error: expected %b, got %b", want.error, m_axis_tuser);
          mismatches++;
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
    $display("simulation failed");
    $finish;
  end

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    src_idle      = 1'b0;
    sink_idle     = 1'b0;
    hold_req      = 1'b0;
    mismatches    = 0;
    n_chars       = 0;
    n_addrs       = 0;
    n_flagged     = 0;
    clear_parse();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_well_formed();
    test_malformed();
    test_backpressure();

    while (pending_addrs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("checked %0d addresses from %0d characters, %0d of them malformed",
             n_addrs, n_chars, n_flagged);
    $display("random idling on both sides plus one long receiver hold that backed up the input");
    if (mismatches == 0 && pending_addrs.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/ite_pkg.sv
hdl/ite_front.sv
hdl/ite_queue.sv
hdl/ite_back.sv
hdl/ipv6_text_expand.sv
hdl/ite_checker.sv
sim/tb.sv
